[hw/rtl/tsc_pkg.sv]
// Shared widths, register codes and item types of the rest length slew controller.
`default_nettype none

package tsc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int VW         = DATA_WIDTH - 1;
	localparam int PW         = 2 * VW - FRAC_BITS;
	localparam int LIM_SPLIT  = PW / 2;
	localparam int LW         = PW + VW - FRAC_BITS;
	localparam int IDX_W      = 3;
	localparam int PIPE_DEPTH = 12;
	localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);
	localparam int S_TDATA_W  = ((3 * VW + DATA_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((3 * VW + 7) / 8) * 8;

	localparam logic [VW-1:0] VMAX = '1;

	localparam logic [VW-1:0] RST_STIFFNESS         = VW'(65536);
	localparam logic [VW-1:0] RST_INV_STIFFNESS     = VW'(65536);
	localparam logic [VW-1:0] RST_STEP_TIME         = VW'(655);
	localparam logic [VW-1:0] RST_INV_STEP_TIME     = VW'(6553600);
	localparam logic [VW-1:0] RST_TARGET_VELOCITY   = VW'(65536);
	localparam logic [VW-1:0] RST_MAX_ACCELERATION  = VW'(65536);
	localparam logic [VW-1:0] RST_MIN_ACTUAL_LENGTH = VW'(0);
	localparam logic [VW-1:0] RST_MIN_REST_LENGTH   = VW'(0);

	typedef enum logic [IDX_W-1:0] {
		REG_STIFFNESS         = 3'd0,
		REG_INV_STIFFNESS     = 3'd1,
		REG_STEP_TIME         = 3'd2,
		REG_INV_STEP_TIME     = 3'd3,
		REG_TARGET_VELOCITY   = 3'd4,
		REG_MAX_ACCELERATION  = 3'd5,
		REG_MIN_ACTUAL_LENGTH = 3'd6,
		REG_MIN_REST_LENGTH   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [VW-1:0] stiffness;
		logic [VW-1:0] inv_stiffness;
		logic [VW-1:0] inv_step_time;
		logic [VW-1:0] target_velocity;
		logic [VW-1:0] min_actual_length;
		logic [VW-1:0] min_rest_length;
		logic [PW-1:0] step;
		logic [PW-1:0] dv;
		logic [LW-1:0] lim;
	} cfg_t;

	typedef struct packed {
		logic [VW-1:0]                target_tension;
		logic [VW-1:0]                measured_length;
		logic [VW-1:0]                present_rest_length;
		logic signed [DATA_WIDTH-1:0] last_velocity;
	} item_t;

	typedef struct packed {
		logic [VW-1:0]                rest;
		logic signed [DATA_WIDTH-1:0] vel;
		logic                         len_gt;
		logic [VW-1:0]                ten;
		logic [VW-1:0]                pref;
	} mid_t;

	typedef struct packed {
		logic [VW-1:0] new_rest_length;
		logic          applied;
		logic [VW-1:0] tension_now;
		logic [VW-1:0] preferred_length;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/tsc_cfg_regs.sv]
// Configuration registers and the products that follow from them alone.
`default_nettype none

module tsc_cfg_regs
	import tsc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             we,
	input  wire logic [IDX_W-1:0] index,
	input  wire logic [VW-1:0]    wdata,
	output cfg_t                  cfg
);

	logic [VW-1:0] stiffness_q, inv_stiffness_q, step_time_q, inv_step_time_q;
	logic [VW-1:0] target_velocity_q, max_acceleration_q;
	logic [VW-1:0] min_actual_length_q, min_rest_length_q;

	logic [PW-1:0] step_q, dv_q;
	logic [LIM_SPLIT+VW-1:0] lim_lo_q;
	logic [PW-LIM_SPLIT+VW-1:0] lim_hi_q;
	logic [LW-1:0] lim_q;

	logic [2*VW-1:0] step_prod, dv_prod;
	logic [PW+VW-1:0] lim_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q         <= RST_STIFFNESS;
			inv_stiffness_q     <= RST_INV_STIFFNESS;
			step_time_q         <= RST_STEP_TIME;
			inv_step_time_q     <= RST_INV_STEP_TIME;
			target_velocity_q   <= RST_TARGET_VELOCITY;
			max_acceleration_q  <= RST_MAX_ACCELERATION;
			min_actual_length_q <= RST_MIN_ACTUAL_LENGTH;
			min_rest_length_q   <= RST_MIN_REST_LENGTH;
		end else if (we) begin
			unique case (index)
				REG_STIFFNESS:         stiffness_q         <= wdata;
				REG_INV_STIFFNESS:     inv_stiffness_q     <= wdata;
				REG_STEP_TIME:         step_time_q         <= wdata;
				REG_INV_STEP_TIME:     inv_step_time_q     <= wdata;
				REG_TARGET_VELOCITY:   target_velocity_q   <= wdata;
				REG_MAX_ACCELERATION:  max_acceleration_q  <= wdata;
				REG_MIN_ACTUAL_LENGTH: min_actual_length_q <= wdata;
				REG_MIN_REST_LENGTH:   min_rest_length_q   <= wdata;
				default: ;
			endcase
		end
	end

	// The second-order limit dv * dt is too wide for one multiplier, so it is
	// formed from two partial products of dv.
	assign step_prod = (2*VW)'(target_velocity_q) * (2*VW)'(step_time_q);
	assign dv_prod   = (2*VW)'(max_acceleration_q) * (2*VW)'(step_time_q);
	assign lim_full  = (PW+VW)'(lim_lo_q) + ((PW+VW)'(lim_hi_q) << LIM_SPLIT);

	always_ff @(posedge clk) begin
		step_q   <= step_prod[2*VW-1:FRAC_BITS];
		dv_q     <= dv_prod[2*VW-1:FRAC_BITS];
		lim_lo_q <= (LIM_SPLIT+VW)'(dv_q[LIM_SPLIT-1:0]) * (LIM_SPLIT+VW)'(step_time_q);
		lim_hi_q <= (PW-LIM_SPLIT+VW)'(dv_q[PW-1:LIM_SPLIT])
			* (PW-LIM_SPLIT+VW)'(step_time_q);
		lim_q    <= lim_full[PW+VW-1:FRAC_BITS];
	end

	assign cfg.stiffness         = stiffness_q;
	assign cfg.inv_stiffness     = inv_stiffness_q;
	assign cfg.inv_step_time     = inv_step_time_q;
	assign cfg.target_velocity   = target_velocity_q;
	assign cfg.min_actual_length = min_actual_length_q;
	assign cfg.min_rest_length   = min_rest_length_q;
	assign cfg.step              = step_q;
	assign cfg.dv                = dv_q;
	assign cfg.lim               = lim_q;

endmodule

`default_nettype wire

[hw/rtl/tsc_tension.sv]
// Stages one to six: present tension and the floored preferred rest length.
`default_nettype none

module tsc_tension
	import tsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	output logic       out_valid,
	input  wire logic  out_ready,
	output mid_t       out_mid
);

	localparam int PRW = PW + 2;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	logic [VW-1:0] tgt_s1, tgt_s2;
	logic [VW-1:0] rest_s1, rest_s2, rest_s3, rest_s4, rest_s5, rest_s6;
	logic signed [DATA_WIDTH-1:0] vel_s1, vel_s2, vel_s3, vel_s4, vel_s5, vel_s6;
	logic lgt_s1, lgt_s2, lgt_s3, lgt_s4, lgt_s5, lgt_s6;
	logic [VW-1:0] ten_s3, ten_s4, ten_s5, ten_s6;
	logic [VW-1:0] mag_s1, mag2_s3;
	logic neg_s1, neg_s2, neg2_s3, neg2_s4;
	logic [PW-1:0] q1_s2, q2_s4;
	logic signed [PRW-1:0] praw_s5;
	logic [VW-1:0] pref_s6;

	logic ge1, ge3, below, above;
	logic [2*VW-1:0] prod1, prod2;
	logic [VW-1:0] ten_c, pref_c;
	logic signed [PRW-1:0] praw_c, min_ext, vmax_ext;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
		end
	end

	assign ge1 = in_item.measured_length >= in_item.present_rest_length;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			tgt_s1  <= in_item.target_tension;
			rest_s1 <= in_item.present_rest_length;
			vel_s1  <= in_item.last_velocity;
			lgt_s1  <= in_item.measured_length > cfg.min_actual_length;
			mag_s1  <= ge1 ? in_item.measured_length - in_item.present_rest_length
				: in_item.present_rest_length - in_item.measured_length;
			neg_s1  <= !ge1;
		end
	end

	assign prod1 = (2*VW)'(mag_s1) * (2*VW)'(cfg.stiffness);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tgt_s2  <= tgt_s1;
			rest_s2 <= rest_s1;
			vel_s2  <= vel_s1;
			lgt_s2  <= lgt_s1;
			q1_s2   <= prod1[2*VW-1:FRAC_BITS];
			neg_s2  <= neg_s1;
		end
	end

	// A negative stretch gives zero tension.
	assign ten_c = neg_s2 ? '0 : ((|q1_s2[PW-1:VW]) ? VMAX : q1_s2[VW-1:0]);
	assign ge3   = tgt_s2 >= ten_c;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			rest_s3 <= rest_s2;
			vel_s3  <= vel_s2;
			lgt_s3  <= lgt_s2;
			ten_s3  <= ten_c;
			mag2_s3 <= ge3 ? tgt_s2 - ten_c : ten_c - tgt_s2;
			neg2_s3 <= !ge3;
		end
	end

	assign prod2 = (2*VW)'(mag2_s3) * (2*VW)'(cfg.inv_stiffness);

	always_ff @(posedge clk) begin
		if (en_s4) begin
			rest_s4 <= rest_s3;
			vel_s4  <= vel_s3;
			lgt_s4  <= lgt_s3;
			ten_s4  <= ten_s3;
			q2_s4   <= prod2[2*VW-1:FRAC_BITS];
			neg2_s4 <= neg2_s3;
		end
	end

	assign praw_c = neg2_s4 ? (PRW'(rest_s4) + PRW'(q2_s4)) : (PRW'(rest_s4) - PRW'(q2_s4));

	always_ff @(posedge clk) begin
		if (en_s5) begin
			rest_s5 <= rest_s4;
			vel_s5  <= vel_s4;
			lgt_s5  <= lgt_s4;
			ten_s5  <= ten_s4;
			praw_s5 <= praw_c;
		end
	end

	assign min_ext  = $signed(PRW'(cfg.min_rest_length));
	assign vmax_ext = $signed(PRW'(VMAX));
	assign below    = praw_s5 < min_ext;
	assign above    = praw_s5 > vmax_ext;
	assign pref_c   = below ? cfg.min_rest_length : (above ? VMAX : praw_s5[VW-1:0]);

	always_ff @(posedge clk) begin
		if (en_s6) begin
			rest_s6 <= rest_s5;
			vel_s6  <= vel_s5;
			lgt_s6  <= lgt_s5;
			ten_s6  <= ten_s5;
			pref_s6 <= pref_c;
		end
	end

	assign out_valid      = v_s6;
	assign out_mid.rest   = rest_s6;
	assign out_mid.vel    = vel_s6;
	assign out_mid.len_gt = lgt_s6;
	assign out_mid.ten    = ten_s6;
	assign out_mid.pref   = pref_s6;

endmodule

`default_nettype wire

[hw/rtl/tsc_slew.sv]
// Stages seven to twelve: velocity and acceleration limited move, apply check, result register.
`default_nettype none

module tsc_slew
	import tsc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire mid_t  in_mid,
	output logic       out_valid,
	input  wire logic  out_ready,
	output res_t       out_res
);

	localparam int E1W = DATA_WIDTH + 2;
	localparam int E2W = PW + 2;
	localparam int MW  = LW + 2;

	logic v_s7, v_s8, v_s9, v_s10, v_s11, v_s12;
	logic en_s7, en_s8, en_s9, en_s10, en_s11, en_s12;

	logic [VW-1:0] rest_s7, rest_s8, rest_s9, rest_s10, rest_s11;
	logic signed [DATA_WIDTH-1:0] vel_s7, vel_s8, vel_s9;
	logic lgt_s7, lgt_s8, lgt_s9;
	logic [VW-1:0] ten_s7, ten_s8, ten_s9, ten_s10, ten_s11, ten_s12;
	logic [VW-1:0] pref_s7, pref_s8, pref_s9, pref_s10, pref_s11, pref_s12;
	logic [VW-1:0] dmag_s7, dmag_s8, dmag_s9;
	logic dneg_s7, dneg_s8, dneg_s9;
	logic dzero_s7, dzero_s8, dzero_s9;
	logic [PW-1:0] q3_s8;
	logic big_s8, big_s9;
	logic signed [E1W-1:0] e1_s8;
	logic ca_s9;
	logic signed [E2W-1:0] e2_s9;
	logic [LW-1:0] dlm_s10;
	logic dln_s10;
	logic signed [MW-1:0] moved_s11;
	logic [VW-1:0] new_rest_s12;
	logic applied_s12;

	logic dpos;
	logic [2*VW-1:0] prod3;
	logic signed [E1W-1:0] tv_ext, sv_c, e1_c;
	logic [E1W-1:0] abs_e1;
	logic signed [E2W-1:0] q3x, velx, e2_c;
	logic [E2W-1:0] abs_e2;
	logic cb, allowed, applied_c;
	logic [LW-1:0] dlm_c;
	logic dln_c;
	logic signed [MW-1:0] moved_c, min_m, vmax_m;

	assign en_s12   = !v_s12 || out_ready;
	assign en_s11   = !v_s11 || en_s12;
	assign en_s10   = !v_s10 || en_s11;
	assign en_s9    = !v_s9 || en_s10;
	assign en_s8    = !v_s8 || en_s9;
	assign en_s7    = !v_s7 || en_s8;
	assign in_ready = en_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else begin
			if (en_s7) v_s7 <= in_valid;
			if (en_s8) v_s8 <= v_s7;
			if (en_s9) v_s9 <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
		end
	end

	assign dpos = in_mid.pref >= in_mid.rest;

	always_ff @(posedge clk) begin
		if (en_s7) begin
			rest_s7  <= in_mid.rest;
			vel_s7   <= in_mid.vel;
			lgt_s7   <= in_mid.len_gt;
			ten_s7   <= in_mid.ten;
			pref_s7  <= in_mid.pref;
			dmag_s7  <= dpos ? in_mid.pref - in_mid.rest : in_mid.rest - in_mid.pref;
			dneg_s7  <= !dpos;
			dzero_s7 <= in_mid.pref == in_mid.rest;
		end
	end

	assign prod3  = (2*VW)'(dmag_s7) * (2*VW)'(cfg.inv_step_time);
	assign tv_ext = $signed(E1W'(cfg.target_velocity));
	assign sv_c   = dzero_s7 ? '0 : (dneg_s7 ? -tv_ext : tv_ext);
	assign e1_c   = sv_c - E1W'(vel_s7);

	always_ff @(posedge clk) begin
		if (en_s8) begin
			rest_s8  <= rest_s7;
			vel_s8   <= vel_s7;
			lgt_s8   <= lgt_s7;
			ten_s8   <= ten_s7;
			pref_s8  <= pref_s7;
			dmag_s8  <= dmag_s7;
			dneg_s8  <= dneg_s7;
			dzero_s8 <= dzero_s7;
			q3_s8    <= prod3[2*VW-1:FRAC_BITS];
			big_s8   <= PW'(dmag_s7) > cfg.step;
			e1_s8    <= e1_c;
		end
	end

	assign abs_e1 = e1_s8[E1W-1] ? E1W'(-e1_s8) : E1W'(e1_s8);
	assign q3x    = $signed(E2W'(q3_s8));
	assign velx   = E2W'(vel_s8);
	assign e2_c   = dneg_s8 ? (-q3x - velx) : (q3x - velx);

	always_ff @(posedge clk) begin
		if (en_s9) begin
			rest_s9  <= rest_s8;
			vel_s9   <= vel_s8;
			lgt_s9   <= lgt_s8;
			ten_s9   <= ten_s8;
			pref_s9  <= pref_s8;
			dmag_s9  <= dmag_s8;
			dneg_s9  <= dneg_s8;
			dzero_s9 <= dzero_s8;
			big_s9   <= big_s8;
			ca_s9    <= PW'(abs_e1) > cfg.dv;
			e2_s9    <= e2_c;
		end
	end

	assign abs_e2  = e2_s9[E2W-1] ? E2W'(-e2_s9) : E2W'(e2_s9);
	assign cb      = abs_e2 > E2W'(cfg.dv);
	assign allowed = lgt_s9 || (!dneg_s9 && !dzero_s9);

	// The move is kept as magnitude and direction until it meets the rest length.
	always_comb begin
		dlm_c = '0;
		dln_c = 1'b0;
		if (!allowed) begin
			dlm_c = '0;
			dln_c = 1'b0;
		end else if (big_s9) begin
			dlm_c = ca_s9 ? cfg.lim : LW'(cfg.step);
			dln_c = dneg_s9;
		end else if (cb) begin
			if (!dzero_s9) begin
				dlm_c = cfg.lim;
				dln_c = dneg_s9;
			end else begin
				// With no difference, the limited move opposes the last velocity.
				dlm_c = (vel_s9 == '0) ? '0 : cfg.lim;
				dln_c = !vel_s9[DATA_WIDTH-1];
			end
		end else begin
			dlm_c = LW'(dmag_s9);
			dln_c = dneg_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s10) begin
			rest_s10 <= rest_s9;
			ten_s10  <= ten_s9;
			pref_s10 <= pref_s9;
			dlm_s10  <= dlm_c;
			dln_s10  <= dln_c;
		end
	end

	assign moved_c = dln_s10 ? (MW'(rest_s10) - MW'(dlm_s10)) : (MW'(rest_s10) + MW'(dlm_s10));

	always_ff @(posedge clk) begin
		if (en_s11) begin
			rest_s11  <= rest_s10;
			ten_s11   <= ten_s10;
			pref_s11  <= pref_s10;
			moved_s11 <= moved_c;
		end
	end

	assign min_m     = $signed(MW'(cfg.min_rest_length));
	assign vmax_m    = $signed(MW'(VMAX));
	assign applied_c = moved_s11 >= min_m;

	always_ff @(posedge clk) begin
		if (en_s12) begin
			applied_s12  <= applied_c;
			new_rest_s12 <= !applied_c ? rest_s11
				: ((moved_s11 > vmax_m) ? VMAX : moved_s11[VW-1:0]);
			ten_s12      <= ten_s11;
			pref_s12     <= pref_s11;
		end
	end

	assign out_valid                = v_s12;
	assign out_res.new_rest_length  = new_rest_s12;
	assign out_res.applied          = applied_s12;
	assign out_res.tension_now      = ten_s12;
	assign out_res.preferred_length = pref_s12;

endmodule

`default_nettype wire

[hw/rtl/tension_rest_length_slew_controller.sv]
// Top level of the tension seeking rest length slew controller for one cable.
// Each accepted item passes through all twelve pipeline stages before its result is valid.
// Throughput: one item per cycle unless the output stalls, as each stage takes a new item every cycle.
// A stalled output backs up stage by stage, so empty stages keep taking items.
// Reset clears every stage valid bit and loads the configuration registers with defaults.
`default_nettype none

module tension_rest_length_slew_controller
	import tsc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// target_tension, measured_length, present_rest_length, last_velocity
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// new_rest_length, tension_now, preferred_length
	output logic [M_TDATA_W-1:0]      m_tdata,
	// applied
	output logic                      m_tuser,
	input  wire logic                 cfg_we,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [VW-1:0]        cfg_wdata
);

	cfg_t  cfg;
	item_t item;
	mid_t  mid;
	res_t  res;
	logic  mid_valid, mid_ready;

	assign item.target_tension      = s_tdata[VW-1:0];
	assign item.measured_length     = s_tdata[2*VW-1:VW];
	assign item.present_rest_length = s_tdata[3*VW-1:2*VW];
	assign item.last_velocity       = $signed(s_tdata[3*VW+DATA_WIDTH-1:3*VW]);

	tsc_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.index (cfg_index),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	tsc_tension u_tension (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.out_valid(mid_valid),
		.out_ready(mid_ready),
		.out_mid  (mid)
	);

	tsc_slew u_slew (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.in_mid   (mid),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (res)
	);

	assign m_tdata = {{(M_TDATA_W-3*VW){1'b0}}, res.preferred_length, res.tension_now,
		res.new_rest_length};
	assign m_tuser = res.applied;

endmodule

`default_nettype wire

[hw/rtl/tsc_checker.sv]
// Port level checker for the controller and the bind that attaches it.
`default_nettype none

module tsc_checker
	import tsc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic                 m_tuser
);

	logic [CNT_W-1:0] cnt_q;
	logic in_acc, out_acc, full;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;
	assign full    = cnt_q == CNT_W'(PIPE_DEPTH);

	// Items accepted and not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	a_no_invented_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> cnt_q != '0)
		else $error("result shown with no item in flight");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PIPE_DEPTH))
		else $error("more items in flight than pipeline stages");

	a_full_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		full && !m_tready |-> !s_tready)
		else $error("input taken while every stage holds an item");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed or dropped");

endmodule

bind tension_rest_length_slew_controller tsc_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

`default_nettype wire
